// ===== rtl/core/dcbt_pkg.sv =====
// Shared constants and types for the dirty card bitmap tracker.
package dcbt_pkg;

  localparam int unsigned MAX_ELEMENTS = 512;
  localparam int unsigned CARD_BYTES   = (MAX_ELEMENTS + 7) / 8;
  localparam int unsigned CARD_AW      = (CARD_BYTES > 1) ? $clog2(CARD_BYTES) : 1;
  localparam int unsigned RANGE_W      = $clog2(CARD_BYTES + 1);

  localparam int unsigned IDX_W  = 9;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned BASE_W = 9;
  localparam int unsigned MASK_W = 8;

  typedef struct packed {
    logic [BASE_W-1:0] group_base;
    logic [MASK_W-1:0] group_mask;
    logic              last;
    logic              card_marked;
    logic              newly_remembered;
  } res_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [CARD_AW-1:0] addr;
    logic [MASK_W-1:0]  wdata;
  } ram_req_t;

endpackage

// ===== rtl/core/dcbt_card_ram.sv =====
// Single-port card bitmap memory, one byte per card, registered read.
module dcbt_card_ram (
  input  logic                      clk_i,
  input  dcbt_pkg::ram_req_t        req_i,
  output logic [dcbt_pkg::MASK_W-1:0] rdata_o
);
  import dcbt_pkg::*;

  logic [MASK_W-1:0] mem [CARD_BYTES];
  logic [MASK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dcbt_out_reg.sv =====
// One-entry result register between the sequencer and the output channel.
module dcbt_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dcbt_pkg::res_t res_i,
  output logic           free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dcbt_pkg::res_t res_o
);
  import dcbt_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i && free_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

// ===== rtl/core/dcbt_ctrl.sv =====
// Sequencer: barrier read-modify-write, dirty range walk, range and flag state.
module dcbt_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       func_i,
  input  logic [dcbt_pkg::IDX_W-1:0] element_index_i,
  input  logic                       container_young_i,
  input  logic                       value_young_i,
  input  logic                       rescan_all_i,
  input  logic [dcbt_pkg::CNT_W-1:0] element_count_i,
  output dcbt_pkg::ram_req_t         ram_req_o,
  input  logic [dcbt_pkg::MASK_W-1:0] ram_rdata_i,
  output logic                       res_push_o,
  output dcbt_pkg::res_t             res_o,
  input  logic                       res_free_i
);
  import dcbt_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_BAR   = 5'b00010,
    ST_RD    = 5'b00100,
    ST_EV    = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  // Element bits of card byte b that lie below count.
  function automatic logic [MASK_W-1:0] below_mask(input logic [RANGE_W-1:0] b,
                                                   input logic [CNT_W-1:0]   cnt);
    logic [CNT_W+1:0] start;
    logic [CNT_W+1:0] cnt_x;
    logic [2:0]       d;
    start = (CNT_W+2)'(b) << 3;
    cnt_x = (CNT_W+2)'(cnt);
    d     = 3'(cnt_x - start);
    if (cnt_x >= start + (CNT_W+2)'(8)) begin
      below_mask = '1;
    end else if (cnt_x <= start) begin
      below_mask = '0;
    end else begin
      below_mask = (MASK_W'(1) << d) - MASK_W'(1);
    end
  endfunction

  state_e              state_q, state_d;
  logic                cfg_q;
  logic                rem_q, rem_d;
  logic [RANGE_W-1:0]  low_q, low_d;
  logic [RANGE_W-1:0]  high_q, high_d;
  logic [CARD_BYTES-1:0] vld_q, vld_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                mark_q, mark_d;
  logic                all_q, all_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RANGE_W-1:0]  scan_b_q, scan_b_d;
  logic [RANGE_W-1:0]  scan_end_q, scan_end_d;
  logic                pend_v_q, pend_v_d;
  logic [BASE_W-1:0]   pend_base_q, pend_base_d;
  logic [MASK_W-1:0]   pend_mask_q, pend_mask_d;

  logic               accept;
  logic               mark_in;
  logic [CNT_W-1:0]   cnt_sat;
  logic [RANGE_W-1:0] groups;
  logic [CARD_AW-1:0] bar_byte;
  logic [RANGE_W-1:0] bar_byte_r;
  logic [MASK_W-1:0]  bar_bit;
  logic [MASK_W-1:0]  bar_old;
  logic [CARD_AW-1:0] scan_addr;
  logic [MASK_W-1:0]  scan_byte;
  logic [MASK_W-1:0]  scan_mask;
  logic [BASE_W-1:0]  scan_base;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign mark_in = cfg_q && !container_young_i && value_young_i &&
                   (CNT_W'(element_index_i) < CNT_W'(MAX_ELEMENTS));
  assign cnt_sat = (element_count_i > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                            : element_count_i;
  assign groups  = RANGE_W'(((CNT_W+1)'(cnt_sat) + (CNT_W+1)'(7)) >> 3);

  assign bar_byte   = CARD_AW'(idx_q >> 3);
  assign bar_byte_r = RANGE_W'(idx_q >> 3);
  assign bar_bit    = MASK_W'(1) << idx_q[2:0];
  assign bar_old    = vld_q[bar_byte] ? ram_rdata_i : '0;

  assign scan_addr = scan_b_q[CARD_AW-1:0];
  assign scan_byte = all_q ? '1 : (vld_q[scan_addr] ? ram_rdata_i : '0);
  assign scan_mask = scan_byte & below_mask(scan_b_q, cnt_q);
  assign scan_base = BASE_W'({scan_b_q, 3'b000});

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    low_d       = low_q;
    high_d      = high_q;
    vld_d       = vld_q;
    idx_d       = idx_q;
    mark_d      = mark_q;
    all_d       = all_q;
    cnt_d       = cnt_q;
    scan_b_d    = scan_b_q;
    scan_end_d  = scan_end_q;
    pend_v_d    = pend_v_q;
    pend_base_d = pend_base_q;
    pend_mask_d = pend_mask_q;
    ram_req_o   = '0;
    res_push_o  = 1'b0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!func_i) begin
            idx_d           = element_index_i;
            mark_d          = mark_in;
            ram_req_o.rd_en = mark_in;
            ram_req_o.addr  = CARD_AW'(element_index_i >> 3);
            state_d         = ST_BAR;
          end else begin
            all_d    = rescan_all_i;
            cnt_d    = cnt_sat;
            pend_v_d = 1'b0;
            if (rescan_all_i) begin
              scan_b_d   = '0;
              scan_end_d = groups;
              state_d    = (groups != '0) ? ST_RD : ST_FLUSH;
            end else begin
              scan_b_d   = low_q;
              scan_end_d = high_q;
              state_d    = (low_q < high_q) ? ST_RD : ST_FLUSH;
            end
          end
        end
      end

      ST_BAR: begin
        if (res_free_i) begin
          res_push_o             = 1'b1;
          res_o.group_base       = idx_q & ~BASE_W'(7);
          res_o.group_mask       = mark_q ? bar_bit : '0;
          res_o.last             = 1'b1;
          res_o.card_marked      = mark_q;
          res_o.newly_remembered = mark_q && !rem_q;
          if (mark_q) begin
            ram_req_o.wr_en  = 1'b1;
            ram_req_o.addr   = bar_byte;
            ram_req_o.wdata  = bar_old | bar_bit;
            vld_d[bar_byte]  = 1'b1;
            rem_d            = 1'b1;
            if (bar_byte_r < low_q) begin
              low_d = bar_byte_r;
            end
            if (bar_byte_r + RANGE_W'(1) > high_q) begin
              high_d = bar_byte_r + RANGE_W'(1);
            end
          end
          state_d = ST_IDLE;
        end
      end

      ST_RD: begin
        ram_req_o.rd_en = !all_q;
        ram_req_o.addr  = scan_addr;
        state_d         = ST_EV;
      end

      ST_EV: begin
        // A found group waits in the pending slot until the next one shows
        // whether it is the final group.
        if (scan_mask == '0 || !pend_v_q || res_free_i) begin
          if (scan_mask != '0) begin
            if (pend_v_q) begin
              res_push_o       = 1'b1;
              res_o.group_base = pend_base_q;
              res_o.group_mask = pend_mask_q;
            end
            pend_v_d    = 1'b1;
            pend_base_d = scan_base;
            pend_mask_d = scan_mask;
          end
          scan_b_d = scan_b_q + RANGE_W'(1);
          state_d  = (scan_b_q + RANGE_W'(1) == scan_end_q) ? ST_FLUSH : ST_RD;
        end
      end

      ST_FLUSH: begin
        if (res_free_i) begin
          res_push_o       = 1'b1;
          res_o.group_base = pend_v_q ? pend_base_q : '0;
          res_o.group_mask = pend_v_q ? pend_mask_q : '0;
          res_o.last       = 1'b1;
          // Every nonzero byte lies inside the dirty range, so dropping all
          // valid bits clears exactly that range.
          vld_d   = '0;
          low_d   = RANGE_W'(CARD_BYTES);
          high_d  = '0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cfg_q    <= 1'b0;
      rem_q    <= 1'b0;
      low_q    <= RANGE_W'(CARD_BYTES);
      high_q   <= '0;
      vld_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rem_q    <= rem_d;
      low_q    <= low_d;
      high_q   <= high_d;
      vld_q    <= vld_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    mark_q      <= mark_d;
    all_q       <= all_d;
    cnt_q       <= cnt_d;
    scan_b_q    <= scan_b_d;
    scan_end_q  <= scan_end_d;
    pend_base_q <= pend_base_d;
    pend_mask_q <= pend_mask_d;
  end

endmodule

// ===== rtl/core/dirty_card_bitmap_tracker.sv =====
// Top level of the dirty card bitmap tracker: card-marking barrier and rescan.
//
//   Channel  Direction  Handshake               Contents
//   cfg      in         cfg_we_i                collections_started (cfg_wdata_i)
//   in       in         in_valid_i / in_ready_o barrier or rescan request
//   out      out        out_valid_o / out_ready_i one group per transaction
//
// A marking barrier reads the card byte from the bitmap RAM, then ORs in the
// element bit and writes the byte back as the result loads. A rescan walks
// the card bytes, each through a RAM read state and then an evaluate state,
// and ends with a flush state that issues the final group; the walk covers
// the dirty byte range, or ceil(count/8) bytes in all-mode.
// Reset clears the per-byte valid bits at once, so no clearing pass is needed;
// a byte whose valid bit is low reads as zero. The output register lets a new
// transaction be taken while a result waits. A barrier result or the final
// group waits in place while the output register is full and not draining;
// the walk also stalls when a second group is found while it is still full.
module dirty_card_bitmap_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [dcbt_pkg::IDX_W-1:0]  element_index_i,
  input  logic                        container_young_i,
  input  logic                        value_young_i,
  input  logic                        rescan_all_i,
  input  logic [dcbt_pkg::CNT_W-1:0]  element_count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dcbt_pkg::BASE_W-1:0] group_base_o,
  output logic [dcbt_pkg::MASK_W-1:0] group_mask_o,
  output logic                        last_o,
  output logic                        card_marked_o,
  output logic                        newly_remembered_o
);
  import dcbt_pkg::*;

  ram_req_t          ram_req;
  logic [MASK_W-1:0] ram_rdata;
  logic              res_push;
  logic              res_free;
  res_t              res_new;
  res_t              res_out;

  dcbt_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .element_index_i   (element_index_i),
    .container_young_i (container_young_i),
    .value_young_i     (value_young_i),
    .rescan_all_i      (rescan_all_i),
    .element_count_i   (element_count_i),
    .ram_req_o         (ram_req),
    .ram_rdata_i       (ram_rdata),
    .res_push_o        (res_push),
    .res_o             (res_new),
    .res_free_i        (res_free)
  );

  // Card bitmap: one byte per 8 elements.
  dcbt_card_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  dcbt_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .res_i       (res_new),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign group_base_o       = res_out.group_base;
  assign group_mask_o       = res_out.group_mask;
  assign last_o             = res_out.last;
  assign card_marked_o      = res_out.card_marked;
  assign newly_remembered_o = res_out.newly_remembered;

endmodule

// ===== rtl/core/dcbt_checker.sv =====
// Port-level checks for the dirty card bitmap tracker, bound to the top level.
module dcbt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [dcbt_pkg::BASE_W-1:0] group_base_o,
  input logic [dcbt_pkg::MASK_W-1:0] group_mask_o,
  input logic                        last_o,
  input logic                        card_marked_o,
  input logic                        newly_remembered_o
);

  // Accepting a transaction takes the block out of its idle state, so in_ready_o drops.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken on two consecutive cycles");

  // A pending result is not withdrawn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped before transfer");

  // A marking barrier reports a single nonzero group and is the last result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && card_marked_o |-> group_mask_o != '0 && last_o)
    else $error("marked barrier result malformed");

  // Only the final result of a transaction may carry an empty mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && group_mask_o == '0 |-> last_o && !newly_remembered_o)
    else $error("empty group not final");

  // Groups start on an 8-element boundary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> group_base_o[2:0] == 3'b000)
    else $error("group base misaligned");

endmodule

bind dirty_card_bitmap_tracker dcbt_checker u_dcbt_checker (.*);

// ===== tb/tb_dirty_card_bitmap_tracker.sv =====
// Testbench for the dirty card bitmap tracker: directed and random barrier/rescan traffic.
`timescale 1ns / 100ps

module tb_dirty_card_bitmap_tracker;
  import dcbt_pkg::*;

  // Operation codes carried on func_i.
  localparam bit OP_BARRIER = 1'b0;
  localparam bit OP_RESCAN  = 1'b1;

  // Generous ceiling on the whole run; only a hang gets anywhere near it.
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // Quiet cycles after the last group before touching the config register.
  localparam int unsigned SETTLE_CYCLES = 16;

  // One pending request for the driver.
  typedef struct {
    bit            op;
    bit [IDX_W-1:0] idx;
    bit            cont_young;
    bit            val_young;
    bit            all_mode;
    bit [CNT_W-1:0] count;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // DUT inputs, all known from time zero.
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  logic              func = OP_BARRIER;
  logic [IDX_W-1:0]  element_index = '0;
  logic              container_young = 1'b0;
  logic              value_young = 1'b0;
  logic              rescan_all = 1'b0;
  logic [CNT_W-1:0]  element_count = '0;
  logic              out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [BASE_W-1:0] group_base;
  logic [MASK_W-1:0] group_mask;
  logic              last;
  logic              card_marked;
  logic              newly_remembered;

  always #2 clk_i = ~clk_i;

  dirty_card_bitmap_tracker i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .func_i             (func),
    .element_index_i    (element_index),
    .container_young_i  (container_young),
    .value_young_i      (value_young),
    .rescan_all_i       (rescan_all),
    .element_count_i    (element_count),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .group_base_o       (group_base),
    .group_mask_o       (group_mask),
    .last_o             (last),
    .card_marked_o      (card_marked),
    .newly_remembered_o (newly_remembered)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the tracker state, updated on every accepted transaction.
  // ---------------------------------------------------------------------------
  bit [7:0]    card_bits [CARD_BYTES];
  int unsigned dirty_lo = CARD_BYTES;   // first dirty byte, CARD_BYTES = empty
  int unsigned dirty_hi = 0;            // one past the last dirty byte
  bit          remembered = 1'b0;       // sticky, only reset clears it
  bit          gc_started = 1'b0;       // shadow of collections_started

  res_t        group_exp_q [$];         // groups still owed by the DUT

  // Stimulus bookkeeping.
  req_t        pending_q [$];
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned n_barriers = 0;
  int unsigned n_marks = 0;
  int unsigned n_rescans = 0;
  int unsigned n_groups = 0;
  int unsigned hot_base = 0;            // element window that random writes favor

  // Handshake flags passed from the sampling edge to the driving edge.
  bit          in_accepted = 1'b0;
  bit          group_taken = 1'b0;
  bit          send_busy = 1'b0;
  int unsigned send_gap = 0;
  int unsigned send_run = 0;
  int unsigned stall_left = 0;
  int unsigned stall_run = 0;

  // Element bits of card byte b that lie below count.
  function automatic bit [7:0] below_count(int unsigned b, int unsigned count);
    int unsigned first;
    first = b * 8;
    if (count >= first + 8) return 8'hFF;
    else if (count <= first) return 8'h00;
    else return 8'((1 << (count - first)) - 1);
  endfunction

  // Mostly back-to-back, sometimes short waits, rarely long ones. A run of
  // zero gaps starts now and then so full-rate stretches also occur.
  function automatic int unsigned pick_gap(inout int unsigned run_left);
    int unsigned r;
    if (run_left != 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) run_left = $urandom_range(30, 80);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 96) return $urandom_range(4, 12);
    else return $urandom_range(20, 40);
  endfunction

  // Work out the groups one accepted transaction must produce and update the
  // shadow bitmap, dirty range and remembered flag.
  function automatic void predict_groups(bit op, bit [IDX_W-1:0] idx, bit cont_young,
                                         bit val_young, bit all_mode,
                                         bit [CNT_W-1:0] count_in);
    res_t        r;
    int unsigned count;
    int unsigned b;
    int unsigned n;
    bit [8:0]    g_base [CARD_BYTES];
    bit [7:0]    g_mask [CARD_BYTES];
    bit [7:0]    m;

    r = '0;
    if (op == OP_BARRIER) begin
      n_barriers++;
      r.group_base = {idx[IDX_W-1:3], 3'b000};
      r.last = 1'b1;
      // Barrier is inert before the first collection, for young containers,
      // for old values, and for slots outside the container.
      if (gc_started && !cont_young && val_young && idx < MAX_ELEMENTS) begin
        b = idx >> 3;
        card_bits[b] |= 8'(1 << idx[2:0]);
        if (b < dirty_lo) dirty_lo = b;
        if (b + 1 > dirty_hi) dirty_hi = b + 1;
        r.group_mask = 8'(1 << idx[2:0]);
        r.card_marked = 1'b1;
        r.newly_remembered = !remembered;
        remembered = 1'b1;
        n_marks++;
      end
      group_exp_q.push_back(r);
      return;
    end

    n_rescans++;
    count = (count_in > MAX_ELEMENTS) ? MAX_ELEMENTS : count_in;
    n = 0;
    if (all_mode) begin
      // Every element below the count, last group partial if needed.
      for (b = 0; b < (count + 7) / 8; b++) begin
        g_base[n] = 9'(b * 8);
        g_mask[n] = below_count(b, count);
        n++;
      end
    end else begin
      // Only dirty bytes with live bits below the count, ascending.
      for (b = dirty_lo; b < dirty_hi && b < CARD_BYTES; b++) begin
        m = card_bits[b] & below_count(b, count);
        if (m != 0) begin
          g_base[n] = 9'(b * 8);
          g_mask[n] = m;
          n++;
        end
      end
    end

    if (n == 0) begin
      // Nothing to report: a single empty group closes the rescan.
      r.last = 1'b1;
      group_exp_q.push_back(r);
    end else begin
      for (b = 0; b < n; b++) begin
        r.group_base = g_base[b];
        r.group_mask = g_mask[b];
        r.last = (b == n - 1);
        group_exp_q.push_back(r);
      end
    end

    // The dirty range is wiped after every rescan, all-mode included.
    for (b = dirty_lo; b < dirty_hi && b < CARD_BYTES; b++) card_bits[b] = 8'h00;
    dirty_lo = CARD_BYTES;
    dirty_hi = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests at the falling edge. Valid stays up with
  // a stable payload until the transaction is taken; the next request may
  // follow at once, so valid gets exactly one update per edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    req_t cur;
    if (in_accepted) begin
      in_accepted = 1'b0;
      send_busy = 1'b0;
    end
    if (!send_busy && rst_ni) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        func <= cur.op;
        element_index <= cur.idx;
        container_young <= cur.cont_young;
        value_young <= cur.val_young;
        rescan_all <= cur.all_mode;
        element_count <= cur.count;
        send_busy = 1'b1;
        send_gap = pick_gap(send_run);
      end
    end
    in_valid <= send_busy;
  end

  // Receiver back-pressure: ready drops for a random while after each group,
  // and also sits low through idle cycles when a stall is running.
  always @(negedge clk_i) begin
    if (group_taken) begin
      group_taken = 1'b0;
      stall_left = pick_gap(stall_run);
    end
    if (rst_ni && stall_left == 0) begin
      out_ready <= 1'b1;
    end else begin
      if (stall_left != 0) stall_left--;
      out_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes at the rising edge. Prediction runs
  // before the check so ordering within the edge never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d groups outstanding",
                 cycle_cnt, group_exp_q.size());
        $display("tb_dirty_card_bitmap_tracker: FAIL");
        $finish;
      end else begin
        if (in_valid && in_ready) begin
          predict_groups(func, element_index, container_young, value_young,
                         rescan_all, element_count);
          items_taken++;
          in_accepted = 1'b1;
        end
        if (out_valid && out_ready) begin
          group_taken = 1'b1;
          if (group_exp_q.size() == 0) begin
            $error("unexpected group: base %0d mask %02h last %0b", group_base,
                   group_mask, last);
            mismatch_cnt++;
          end else begin
            want = group_exp_q.pop_front();
            n_groups++;
            if (group_base !== want.group_base) begin
              $error("group_base: expected %0d, got %0d", want.group_base, group_base);
              mismatch_cnt++;
            end
            if (group_mask !== want.group_mask) begin
              $error("group_mask: expected %02h, got %02h", want.group_mask, group_mask);
              mismatch_cnt++;
            end
            if (last !== want.last) begin
              $error("last: expected %0b, got %0b", want.last, last);
              mismatch_cnt++;
            end
            if (card_marked !== want.card_marked) begin
              $error("card_marked: expected %0b, got %0b", want.card_marked, card_marked);
              mismatch_cnt++;
            end
            if (newly_remembered !== want.newly_remembered) begin
              $error("newly_remembered: expected %0b, got %0b", want.newly_remembered,
                     newly_remembered);
              mismatch_cnt++;
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_barrier(int unsigned idx, bit cont_young, bit val_young);
    req_t q;
    q.op = OP_BARRIER;
    q.idx = IDX_W'(idx);
    q.cont_young = cont_young;
    q.val_young = val_young;
    // Rescan-only fields carry noise; the barrier must ignore them.
    q.all_mode = 1'($urandom());
    q.count = CNT_W'($urandom());
    pending_q.push_back(q);
    items_queued++;
  endtask

  task automatic queue_rescan(bit all_mode, int unsigned count);
    req_t q;
    q.op = OP_RESCAN;
    q.all_mode = all_mode;
    q.count = CNT_W'(count);
    // Barrier-only fields carry noise; the rescan must ignore them.
    q.idx = IDX_W'($urandom());
    q.cont_young = 1'($urandom());
    q.val_young = 1'($urandom());
    pending_q.push_back(q);
    items_queued++;
  endtask

  // Hold the sender until every transaction is in and every group is out.
  task automatic wait_idle();
    while (items_taken != items_queued || group_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Only called while idle, so the shadow can follow at once.
  task automatic write_started(bit v);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    gc_started = v;
  endtask

  // Mostly store-like barrier traffic that actually marks, clustered around a
  // moving window so bytes collect several bits; rescans mostly in dirty mode
  // with counts that cut into the marked range. Long all-mode walks are rare.
  task automatic queue_random(int unsigned n);
    int unsigned r;
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) hot_base = $urandom_range(0, MAX_ELEMENTS - 1);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 0)
          queue_barrier((hot_base + $urandom_range(0, 47)) % MAX_ELEMENTS,
                        $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0);
        else
          queue_barrier($urandom_range(0, MAX_ELEMENTS - 1),
                        $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0);
      end else begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
          if (r < 85) queue_rescan(1'b1, $urandom_range(0, 72));
          else if (r < 95) queue_rescan(1'b1, $urandom_range(73, MAX_ELEMENTS - 1));
          else queue_rescan(1'b1, $urandom_range(MAX_ELEMENTS, 1023));
        end else begin
          if (r < 15) queue_rescan(1'b0, $urandom_range(MAX_ELEMENTS + 1, 1023));
          else if (r < 20) queue_rescan(1'b0, MAX_ELEMENTS);
          else queue_rescan(1'b0, $urandom_range(0, MAX_ELEMENTS - 1));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    foreach (card_bits[i]) card_bits[i] = 8'h00;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Before the first collection: a marking-shaped write stays inert and a
    // rescan has nothing to report.
    write_started(1'b0);
    queue_barrier(100, 1'b0, 1'b1);
    queue_rescan(1'b0, MAX_ELEMENTS);
    wait_idle();

    write_started(1'b1);
    queue_barrier(0, 1'b0, 1'b1);                // first mark remembers
    queue_barrier(MAX_ELEMENTS - 1, 1'b0, 1'b1); // top slot, already remembered
    queue_barrier(13, 1'b1, 1'b1);               // young container
    queue_barrier(14, 1'b0, 1'b0);               // old value
    queue_barrier(13, 1'b1, 1'b0);
    queue_barrier(9, 1'b0, 1'b1);
    queue_barrier(9, 1'b0, 1'b1);                // same bit marked twice
    queue_rescan(1'b0, 10);                      // count cuts byte 1, drops byte 63
    queue_rescan(1'b0, 1023);                    // range already wiped: empty group
    queue_barrier(300, 1'b0, 1'b1);
    queue_barrier(301, 1'b0, 1'b1);
    queue_barrier(7, 1'b0, 1'b1);
    queue_rescan(1'b0, 1023);                    // count saturates
    queue_rescan(1'b1, 0);                       // all-mode, nothing below count
    queue_rescan(1'b1, 13);                      // partial last group
    queue_rescan(1'b1, 1023);                    // every group, saturated count
    queue_barrier(40, 1'b0, 1'b1);
    queue_rescan(1'b1, 8);                       // all-mode still wipes the range
    queue_rescan(1'b0, MAX_ELEMENTS);
    queue_barrier(504, 1'b0, 1'b1);
    queue_rescan(1'b0, 505);
    wait_idle();

    queue_random(150);
    wait_idle();

    // Collection flag dropped: marks stop, old dirty state drains by rescans.
    queue_barrier(200, 1'b0, 1'b1);
    wait_idle();
    write_started(1'b0);
    queue_random(50);
    wait_idle();

    write_started(1'b1);
    queue_random(50);
    wait_idle();
    queue_random(50);
    wait_idle();
    repeat (32) @(negedge clk_i);

    $display("covered %0d barrier writes (%0d marked) and %0d rescans, %0d groups checked",
             n_barriers, n_marks, n_rescans, n_groups);
    $display("collections_started toggled 0/1, back-pressure and idle gaps on both sides");
    if (mismatch_cnt == 0 && group_exp_q.size() == 0) begin
      $display("tb_dirty_card_bitmap_tracker: PASS");
    end else begin
      $display("tb_dirty_card_bitmap_tracker: FAIL");
    end
    $finish;
  end

endmodule
